// File: rtl/core/hav_pkg.sv
// Shared types, constants and fixed-point helpers for the haversine distance pipeline.
// No dependencies; used by every file in rtl/core.
package hav_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS        = 30;
    localparam int SQRT_STEPS          = 31;
    localparam int SQRT_W              = 62;

    localparam logic [15:0] RADIUS_RESET = 16'd3961;
    localparam logic [26:0] RAD_K =
        27'(((64'd314159 << 32) + 64'd9000000) / 64'd18000000);

    localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
    localparam logic signed [33:0] Q30_PI       = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_INV     = 34'sd652032874;
    localparam logic [25:0]        DIST_MAX     = 26'h3FFFFFF;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } cordic_t;

    typedef struct packed {
        logic              valid;
        logic              invalid;
        cordic_t [3:0]     lane;
    } rot_beat_t;

    typedef struct packed {
        logic                          valid;
        logic                          invalid;
        logic [1:0][SQRT_W-1:0]        v;
        logic [1:0][SQRT_W-1:0]        r;
    } sqrt_beat_t;

    typedef struct packed {
        logic    valid;
        logic    invalid;
        cordic_t vec;
    } vec_beat_t;

    typedef struct packed {
        logic [25:0] distance;
        logic        invalid;
    } result_t;

    // Q30 product, rounded half up toward +inf after floor shift
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
        return p[63:30];
    endfunction

endpackage

// File: rtl/core/hav_rot_cell.sv
// One CORDIC rotation step for four lanes (sin/cos), registered.
// Depends on hav_pkg.
module hav_rot_cell
    import hav_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  rot_beat_t beat_in,
    output rot_beat_t beat_out
);

    localparam logic signed [32:0] ANG = $signed({1'b0, ATAN_TAB[STEP]});

    rot_beat_t beat_reg;
    rot_beat_t beat_next;

    always_comb
    begin
        beat_next = beat_in;
        for (int i = 0; i < 4; i++)
        begin
            if ($signed(beat_in.lane[i].z) >= 0)
            begin
                beat_next.lane[i].x = beat_in.lane[i].x - ($signed(beat_in.lane[i].y) >>> STEP);
                beat_next.lane[i].y = beat_in.lane[i].y + ($signed(beat_in.lane[i].x) >>> STEP);
                beat_next.lane[i].z = beat_in.lane[i].z - ANG;
            end
            else
            begin
                beat_next.lane[i].x = beat_in.lane[i].x + ($signed(beat_in.lane[i].y) >>> STEP);
                beat_next.lane[i].y = beat_in.lane[i].y - ($signed(beat_in.lane[i].x) >>> STEP);
                beat_next.lane[i].z = beat_in.lane[i].z + ANG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

// File: rtl/core/hav_sqrt_cell.sv
// One two-bit step of the integer square root for two lanes, registered.
// Depends on hav_pkg.
module hav_sqrt_cell
    import hav_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  sqrt_beat_t beat_in,
    output sqrt_beat_t beat_out
);

    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

    sqrt_beat_t beat_reg;
    sqrt_beat_t beat_next;

    always_comb
    begin
        beat_next = beat_in;
        for (int i = 0; i < 2; i++)
        begin
            if (beat_in.v[i] >= beat_in.r[i] + BIT)
            begin
                beat_next.v[i] = beat_in.v[i] - (beat_in.r[i] + BIT);
                beat_next.r[i] = (beat_in.r[i] >> 1) + BIT;
            end
            else
            begin
                beat_next.r[i] = beat_in.r[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

// File: rtl/core/hav_vec_cell.sv
// One CORDIC vectoring step (atan2), registered.
// Depends on hav_pkg.
module hav_vec_cell
    import hav_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  vec_beat_t beat_in,
    output vec_beat_t beat_out
);

    localparam logic signed [32:0] ANG = $signed({1'b0, ATAN_TAB[STEP]});

    vec_beat_t beat_reg;
    vec_beat_t beat_next;

    always_comb
    begin
        beat_next = beat_in;
        if ($signed(beat_in.vec.y) > 0)
        begin
            beat_next.vec.x = beat_in.vec.x + ($signed(beat_in.vec.y) >>> STEP);
            beat_next.vec.y = beat_in.vec.y - ($signed(beat_in.vec.x) >>> STEP);
            beat_next.vec.z = beat_in.vec.z + ANG;
        end
        else
        begin
            beat_next.vec.x = beat_in.vec.x - ($signed(beat_in.vec.y) >>> STEP);
            beat_next.vec.y = beat_in.vec.y + ($signed(beat_in.vec.x) >>> STEP);
            beat_next.vec.z = beat_in.vec.z - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

// File: rtl/core/haversine_distance.sv
// Haversine great-circle distance, top level: range check, radians, CORDIC and sqrt
// cell chains, scaling, output register with skid. Depends on hav_pkg and the hav_* cells.
//
//  channel   | dir | beat contents
//  s_axis    | in  | tdata: first_lat, first_lon, second_lat, second_lon (32b each)
//  m_axis    | out | tdata: distance (26b); tuser: invalid
//  cfg       | in  | earth_radius_miles (16b), written when cfg_wr_en is high
//
// One pair per cycle unless stalled; the path to the output register has 30 rotation cells,
// 31 square root cells and 30 vectoring cells, plus 6 arithmetic stages.
// The pipeline stalls only while the skid stage holds a beat.
// Reset clears all valid bits and loads radius 3961.
module haversine_distance
    import hav_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // first_lat, first_lon, second_lat, second_lon
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // distance, zero pad
    output logic         m_axis_tuser,   // invalid
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);

    localparam int SH = ANGLE_FRAC_BITS + 2;
    localparam logic signed [33:0] LAT_LIM = 34'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [33:0] LON_LIM = 34'(180) <<< ANGLE_FRAC_BITS;

    logic        en;
    logic [15:0] radius_reg;

    // stage 0: range check and magnitudes
    logic             v0_reg, v0_next;
    logic             inv0_reg, inv0_next;
    logic [3:0][31:0] abs0_reg, abs0_next;
    logic [3:0]       neg0_reg, neg0_next;
    // stage 1: radian products
    logic             v1_reg;
    logic             inv1_reg;
    logic [3:0][58:0] m1_reg, m1_next;
    logic [3:0]       neg1_reg;
    // stage 2: radians
    logic                    v2_reg;
    logic                    inv2_reg;
    logic [3:0][32:0]        rad2_reg, rad2_next;
    // products
    logic               v4_reg, inv4_reg;
    logic signed [33:0] sqlat4_reg, cc4_reg, sqlon4_reg;
    logic               v5_reg, inv5_reg;
    logic signed [33:0] sqlat5_reg, t5_reg;
    // scaling
    logic               v8_reg, v8_next;
    logic               inv8_reg, inv8_next;
    logic [48:0]        prod8_reg, prod8_next;

    rot_beat_t  rot_chain  [CORDIC_STEPS+1];
    sqrt_beat_t sqrt_chain [SQRT_STEPS+1];
    vec_beat_t  vec_chain  [CORDIC_STEPS+1];

    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_full_reg;
    logic    push, pop;

    assign en            = ~skid_full_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    // stage 0
    always_comb
    begin
        logic signed [33:0] c [4];
        for (int i = 0; i < 4; i++)
        begin
            c[i] = $signed({{2{s_axis_tdata[32*i+31]}}, s_axis_tdata[32*i +: 32]});
            neg0_next[i] = s_axis_tdata[32*i+31];
            abs0_next[i] = s_axis_tdata[32*i+31] ? 32'(-s_axis_tdata[32*i +: 32])
                                                 : s_axis_tdata[32*i +: 32];
        end
        inv0_next = (c[0] > LAT_LIM) || (c[0] < -LAT_LIM) || (c[2] > LAT_LIM) ||
                    (c[2] < -LAT_LIM) || (c[1] > LON_LIM) || (c[1] < -LON_LIM) ||
                    (c[3] > LON_LIM) || (c[3] < -LON_LIM);
        v0_next   = s_axis_tvalid;
    end

    // stage 1 and 2
    always_comb
    begin
        logic [59:0] rsum;
        logic [31:0] rmag;
        for (int i = 0; i < 4; i++)
        begin
            m1_next[i] = 59'(abs0_reg[i]) * 59'(RAD_K);
        end
        for (int i = 0; i < 4; i++)
        begin
            rsum = {1'b0, m1_reg[i]} + (60'(1) << (SH - 1));
            rmag = 32'(rsum >> SH);
            rad2_next[i] = neg1_reg[i] ? 33'(-{1'b0, rmag}) : {1'b0, rmag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= v0_next;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v4_reg <= rot_chain[CORDIC_STEPS].valid;
            v5_reg <= v4_reg;
            v8_reg <= v8_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv0_reg   <= inv0_next;
            abs0_reg   <= abs0_next;
            neg0_reg   <= neg0_next;
            inv1_reg   <= inv0_reg;
            m1_reg     <= m1_next;
            neg1_reg   <= neg0_reg;
            inv2_reg   <= inv1_reg;
            rad2_reg   <= rad2_next;
            inv4_reg   <= rot_chain[CORDIC_STEPS].invalid;
            sqlat4_reg <= mulq(rot_chain[CORDIC_STEPS].lane[0].y,
                               rot_chain[CORDIC_STEPS].lane[0].y);
            cc4_reg    <= mulq(rot_chain[CORDIC_STEPS].lane[1].x,
                               rot_chain[CORDIC_STEPS].lane[2].x);
            sqlon4_reg <= mulq(rot_chain[CORDIC_STEPS].lane[3].y,
                               rot_chain[CORDIC_STEPS].lane[3].y);
            inv5_reg   <= inv4_reg;
            sqlat5_reg <= sqlat4_reg;
            t5_reg     <= mulq(cc4_reg, sqlon4_reg);
            inv8_reg   <= inv8_next;
            prod8_reg  <= prod8_next;
        end
    end

    // half differences folded into [-pi/2, pi/2]; cos lanes take latitudes directly
    always_comb
    begin
        logic signed [33:0] diff;
        logic signed [33:0] h;
        rot_chain[0].valid   = v2_reg;
        rot_chain[0].invalid = inv2_reg;
        for (int i = 0; i < 4; i++)
        begin
            rot_chain[0].lane[i].x = GAIN_INV;
            rot_chain[0].lane[i].y = '0;
        end
        rot_chain[0].lane[1].z = $signed(rad2_reg[0]);
        rot_chain[0].lane[2].z = $signed(rad2_reg[2]);
        for (int k = 0; k < 2; k++)
        begin
            diff = $signed({rad2_reg[2+k][32], rad2_reg[2+k]})
                 - $signed({rad2_reg[k][32], rad2_reg[k]});
            h = diff >>> 1;
            if (h > Q30_HALF_PI)
            begin
                h = h - Q30_PI;
            end
            else if (h < -Q30_HALF_PI)
            begin
                h = h + Q30_PI;
            end
            rot_chain[0].lane[3*k].z = h[32:0];
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_rot
        hav_rot_cell #(.STEP(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .beat_in (rot_chain[g]),
            .beat_out(rot_chain[g+1])
        );
    end

    // a clamped to [0, 1], then both square-root lanes
    always_comb
    begin
        logic signed [34:0] a;
        logic [30:0]        ac;
        logic [30:0]        bc;
        a = 35'(sqlat5_reg) + 35'(t5_reg);
        if (a < 0)
        begin
            ac = '0;
        end
        else if (a > 35'(Q30_ONE))
        begin
            ac = 31'(Q30_ONE);
        end
        else
        begin
            ac = a[30:0];
        end
        bc = 31'(Q30_ONE) - ac;
        sqrt_chain[0].valid   = v5_reg;
        sqrt_chain[0].invalid = inv5_reg;
        sqrt_chain[0].v[0]    = {1'b0, ac, 30'b0};
        sqrt_chain[0].v[1]    = {1'b0, bc, 30'b0};
        sqrt_chain[0].r       = '0;
    end

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        hav_sqrt_cell #(.STEP(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .beat_in (sqrt_chain[g]),
            .beat_out(sqrt_chain[g+1])
        );
    end

    always_comb
    begin
        vec_chain[0].valid   = sqrt_chain[SQRT_STEPS].valid;
        vec_chain[0].invalid = sqrt_chain[SQRT_STEPS].invalid;
        vec_chain[0].vec.y   = $signed({1'b0, sqrt_chain[SQRT_STEPS].r[0][32:0]});
        vec_chain[0].vec.x   = $signed({1'b0, sqrt_chain[SQRT_STEPS].r[1][32:0]});
        vec_chain[0].vec.z   = '0;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_vec
        hav_vec_cell #(.STEP(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .beat_in (vec_chain[g]),
            .beat_out(vec_chain[g+1])
        );
    end

    // c = 2*angle, clamped at zero, times radius
    always_comb
    begin
        logic signed [33:0] c;
        logic [32:0]        cu;
        c  = $signed({vec_chain[CORDIC_STEPS].vec.z, 1'b0});
        cu = (c < 0) ? '0 : c[32:0];
        v8_next    = vec_chain[CORDIC_STEPS].valid;
        inv8_next  = vec_chain[CORDIC_STEPS].invalid;
        prod8_next = 49'(radius_reg) * 49'(cu);
    end

    always_comb
    begin
        logic [49:0] rnd;
        logic [27:0] d;
        rnd = {1'b0, prod8_reg} + (50'(1) << 21);
        d   = 28'(rnd >> 22);
        res_next.invalid = inv8_reg;
        if (inv8_reg)
        begin
            res_next.distance = '0;
        end
        else if (d > 28'(DIST_MAX))
        begin
            res_next.distance = DIST_MAX;
        end
        else
        begin
            res_next.distance = d[25:0];
        end
    end

    // output register with skid
    assign push = en & v8_reg;
    assign pop  = out_valid_reg & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (pop)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_full_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.distance};
    assign m_axis_tuser  = out_reg.invalid;

endmodule
